### rtl/liquify_brush_grid_assert.svh
// Assertion macros shared by the liquify brush grid modules.
`ifndef LIQUIFY_BRUSH_GRID_ASSERT_SVH
`define LIQUIFY_BRUSH_GRID_ASSERT_SVH
// Same-edge implication, held off while reset is low.
`define LBG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbg: same-cycle check failed");
// Next-edge implication, held off while reset is low.
`define LBG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbg: next-cycle check failed");
`endif

### rtl/lbg_pkg.sv
// Types, codes and table builders for the liquify brush grid.
package lbg_pkg;

    localparam logic [1:0] CMD_BRUSH = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [2:0] KIND_PUSH  = 3'd0;
    localparam logic [2:0] KIND_PULL  = 3'd1;
    localparam logic [2:0] KIND_PINCH = 3'd2;
    localparam logic [2:0] KIND_BLOAT = 3'd3;
    localparam logic [2:0] KIND_TWIRL = 3'd4;

    localparam int          SINE_QTR = 256;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         view_slot;
        logic [2:0]         brush_kind;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [14:0]        brush_radius;
        logic signed [15:0] brush_strength;
        logic signed [15:0] push_dx;
        logic signed [15:0] push_dy;
        logic [9:0]         cell_index;
    } t_req;

    typedef struct packed {
        logic signed [23:0] disp_x;
        logic signed [23:0] disp_y;
        logic [10:0]        cells_changed;
        logic               saturated;
    } t_rsp;

    typedef struct packed {
        logic load_item;
        logic start;
        logic init_wr;
        logic clr_wr;
        logic rd_item;
        logic rd_cell;
        logic dist_ld;
        logic sum_ld;
        logic div_ld;
        logic div_step;
        logic g_ld;
        logic w_ld;
        logic ang_ld;
        logic mul_ld;
        logic delta_ld;
        logic cell_wr;
        logic next_cell;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       slot_ok;
        logic       kind_ok;
        logic       init_last;
        logic       last_cell;
        logic       in_radius;
        logic       div_last;
        logic       out_full;
    } t_sts;

    function automatic logic [16:0] q30_to_q16(input longint s);
        longint t;
        t = (s < 0) ? 64'sd0 : s;
        t = (t + 64'sd8192) >>> 14;
        if (t > 64'sd65536) t = 64'sd65536;
        return 17'(t);
    endfunction

    // exp(-x) as a series for exp(-x/16), then four squarings; b is x/16 in Q30
    function automatic logic [16:0] gauss_entry(input logic [63:0] b);
        logic [63:0] term;
        logic [63:0] s;
        longint      sum;
        term = 64'd1 << 30;
        sum  = longint'(64'd1 << 30);
        for (int k = 1; k <= 10; k++) begin
            term = ((term * b) >> 30) / 64'(k);
            if ((k & 1) != 0) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        s = 64'(sum);
        for (int k = 0; k < 4; k++) begin
            s = (s * s + (64'd1 << 29)) >> 30;
        end
        return q30_to_q16(longint'(s));
    endfunction

    // quarter-wave sine, Q16
    function automatic logic [16:0] sine_entry(input int i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (PI_Q30 * 64'(i)) / 64'(2 * SINE_QTR);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        return q30_to_q16(sum);
    endfunction

endpackage

### rtl/lbg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lbg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/lbg_ctrl.sv
// Sequencer for the liquify brush grid: decodes requests and steps the datapath.
`include "liquify_brush_grid_assert.svh"
module lbg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output lbg_pkg::t_ctl o_ctl,
    input  lbg_pkg::t_sts i_sts
);
    import lbg_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_CLEAR, S_READ,
        S_BR_DIST, S_BR_SUM, S_BR_TEST, S_BR_DIV, S_BR_GAUSS,
        S_BR_WGT, S_BR_ANG, S_BR_MUL, S_BR_DELTA, S_BR_WR, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_ctl   ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        case (r_state)
            S_INIT: begin
                ctl.init_wr = 1'b1;
                if (i_sts.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    ctl.load_item = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                ctl.start = 1'b1;
                if (!i_sts.slot_ok) begin
                    n_state = S_DONE;
                end else begin
                    case (i_sts.cmd)
                        CMD_BRUSH: n_state = i_sts.kind_ok ? S_BR_DIST : S_DONE;
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_READ:  n_state = S_READ;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                ctl.clr_wr    = 1'b1;
                ctl.next_cell = 1'b1;
                if (i_sts.last_cell) n_state = S_DONE;
            end
            S_READ: begin
                ctl.rd_item = 1'b1;
                n_state     = S_DONE;
            end
            S_BR_DIST: begin
                ctl.dist_ld = 1'b1;
                ctl.rd_cell = 1'b1;
                n_state     = S_BR_SUM;
            end
            S_BR_SUM: begin
                ctl.sum_ld = 1'b1;
                n_state    = S_BR_TEST;
            end
            S_BR_TEST: begin
                if (i_sts.in_radius) begin
                    ctl.div_ld = 1'b1;
                    n_state    = S_BR_DIV;
                end else begin
                    ctl.next_cell = 1'b1;
                    n_state       = i_sts.last_cell ? S_DONE : S_BR_DIST;
                end
            end
            S_BR_DIV: begin
                ctl.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_BR_GAUSS;
            end
            S_BR_GAUSS: begin
                ctl.g_ld = 1'b1;
                n_state  = S_BR_WGT;
            end
            S_BR_WGT: begin
                ctl.w_ld = 1'b1;
                n_state  = S_BR_ANG;
            end
            S_BR_ANG: begin
                ctl.ang_ld = 1'b1;
                n_state    = S_BR_MUL;
            end
            S_BR_MUL: begin
                ctl.mul_ld = 1'b1;
                n_state    = S_BR_DELTA;
            end
            S_BR_DELTA: begin
                ctl.delta_ld = 1'b1;
                n_state      = S_BR_WR;
            end
            S_BR_WR: begin
                ctl.cell_wr   = 1'b1;
                ctl.next_cell = 1'b1;
                n_state       = i_sts.last_cell ? S_DONE : S_BR_DIST;
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    ctl.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ctl       = ctl;
    assign o_req_ready = (r_state == S_IDLE);

    // only cells inside the radius are written back
    `LBG_ASSERT_IMP(a_wr_inside, i_clk, i_rst_n, r_state == S_BR_WR, i_sts.in_radius)
    `LBG_ASSERT_NXT(a_div_ends, i_clk, i_rst_n, (r_state == S_BR_DIV) && i_sts.div_last, r_state == S_BR_GAUSS)
endmodule

### rtl/lbg_dp.sv
// Datapath: cell walk, distance test, Gaussian weight, brush math, grid RAM, result.
`include "liquify_brush_grid_assert.svh"
module lbg_dp #(
    parameter int GRID_DIM       = 32,
    parameter int NUM_VIEWS      = 4,
    parameter int EXP_TABLE_SIZE = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lbg_pkg::t_ctl i_ctl,
    output lbg_pkg::t_sts o_sts,
    input  lbg_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output lbg_pkg::t_rsp o_rsp
);
    import lbg_pkg::*;

    localparam int CELLS = GRID_DIM * GRID_DIM;
    localparam int TOTAL = NUM_VIEWS * CELLS;
    localparam int AW    = $clog2(TOTAL);
    localparam int GW    = $clog2(GRID_DIM);
    localparam int TWO_G = 2 * GRID_DIM;
    localparam int C0_Q  = 16384 / TWO_G;
    localparam int C0_R  = 16384 % TWO_G;
    localparam int ST_Q  = 32768 / TWO_G;
    localparam int ST_R  = 32768 % TWO_G;
    localparam int RW    = $clog2(2 * TWO_G) + 1;
    localparam int QW    = $clog2(EXP_TABLE_SIZE + 1);
    localparam int NW    = 31 + QW;
    localparam int CW    = $clog2(QW);

    t_req               r_item;
    logic [GW-1:0]      r_gx, r_gy;
    logic [13:0]        r_cu, r_cv;
    logic [RW-1:0]      r_ur, r_vr;
    logic [AW-1:0]      r_addr;
    logic [29:0]        r_r2;
    logic signed [17:0] r_du, r_dv;
    logic signed [35:0] r_du2, r_dv2;
    logic [33:0]        r_d2;
    logic [NW-1:0]      r_rem, r_dsor;
    logic [QW-1:0]      r_q;
    logic [CW-1:0]      r_dcnt;
    logic [16:0]        r_g;
    logic signed [33:0] r_w30;
    logic signed [18:0] r_s, r_cm;
    logic signed [51:0] r_pa, r_pb;
    logic signed [36:0] r_t1, r_t2, r_t3, r_t4;
    logic signed [25:0] r_ex, r_ey;
    logic [10:0]        r_count;
    logic               r_sat;
    logic               r_out_valid;
    t_rsp               r_rsp;

    logic [16:0] gauss_rom [0:EXP_TABLE_SIZE];
    logic [16:0] sine_rom  [0:SINE_QTR];

    for (genvar gi = 0; gi <= EXP_TABLE_SIZE; gi++) begin : g_gauss
        localparam logic [63:0] B = (64'(gi) << 28) / EXP_TABLE_SIZE;
        assign gauss_rom[gi] = gauss_entry(B);
    end

    for (genvar si = 0; si <= SINE_QTR; si++) begin : g_sine
        assign sine_rom[si] = sine_entry(si);
    end

    // ---------------- decode ----------------
    logic          slot_ok, idx_ok, kind_ok, read_ok, last_col, last_cell, in_radius;
    logic [AW-1:0] base_c, rd_addr;

    assign slot_ok   = 32'(r_item.view_slot) < NUM_VIEWS;
    assign idx_ok    = 32'(r_item.cell_index) < CELLS;
    assign kind_ok   = r_item.brush_kind <= KIND_TWIRL;
    assign read_ok   = (r_item.cmd == CMD_READ) && slot_ok && idx_ok;
    assign base_c    = AW'(r_item.view_slot) * AW'(CELLS);
    assign rd_addr   = base_c + AW'(r_item.cell_index);
    assign last_col  = r_gx == GW'(GRID_DIM - 1);
    assign last_cell = last_col && (r_gy == GW'(GRID_DIM - 1));
    assign in_radius = r_d2 <= {4'b0000, r_r2};

    // ---------------- cell centers, stepped by quotient and remainder ----------------
    logic [RW-1:0] ur_sum, vr_sum;
    logic          u_carry, v_carry;
    assign ur_sum  = r_ur + RW'(ST_R);
    assign vr_sum  = r_vr + RW'(ST_R);
    assign u_carry = ur_sum >= RW'(TWO_G);
    assign v_carry = vr_sum >= RW'(TWO_G);

    logic signed [17:0] du_c, dv_c, px_e, py_e;
    assign du_c = $signed({4'b0000, r_cu})
                - $signed({{2{r_item.center_x[15]}}, r_item.center_x});
    assign dv_c = $signed({4'b0000, r_cv})
                - $signed({{2{r_item.center_y[15]}}, r_item.center_y});
    assign px_e = $signed({{2{r_item.push_dx[15]}}, r_item.push_dx});
    assign py_e = $signed({{2{r_item.push_dy[15]}}, r_item.push_dy});

    // ---------------- divider step ----------------
    logic rem_ge;
    assign rem_ge = r_rem >= r_dsor;

    logic [QW-1:0] q_idx;
    assign q_idx = (r_q > QW'(EXP_TABLE_SIZE)) ? QW'(EXP_TABLE_SIZE) : r_q;

    // ---------------- twirl angle to sine and cosine ----------------
    logic signed [33:0] ang_sum;
    logic [9:0]         ang, ang_c;
    logic [8:0]         s_idx, c_idx;
    logic signed [18:0] s_val, c_val;
    assign ang_sum = r_w30 + 34'sd1048576;
    assign ang     = ang_sum[30:21];
    assign ang_c   = ang + 10'd256;
    assign s_idx   = ang[8]   ? 9'd256 - {1'b0, ang[7:0]}   : {1'b0, ang[7:0]};
    assign c_idx   = ang_c[8] ? 9'd256 - {1'b0, ang_c[7:0]} : {1'b0, ang_c[7:0]};
    assign s_val   = ang[9]   ? -$signed({2'b00, sine_rom[s_idx]}) : $signed({2'b00, sine_rom[s_idx]});
    assign c_val   = ang_c[9] ? -$signed({2'b00, sine_rom[c_idx]}) : $signed({2'b00, sine_rom[c_idx]});

    logic               pp_kind;
    logic signed [17:0] ax, ay;
    assign pp_kind = (r_item.brush_kind == KIND_PUSH) || (r_item.brush_kind == KIND_PULL);
    assign ax      = pp_kind ? px_e : r_du;
    assign ay      = pp_kind ? py_e : r_dv;

    // ---------------- deltas ----------------
    logic signed [51:0] pa_r, pb_r;
    logic signed [37:0] tx, ty;
    logic signed [25:0] ex_c, ey_c;
    assign pa_r = r_pa + 52'sd33554432;
    assign pb_r = r_pb + 52'sd33554432;
    assign tx   = {r_t1[36], r_t1} - {r_t2[36], r_t2} + 38'sd2048;
    assign ty   = {r_t3[36], r_t3} + {r_t4[36], r_t4} + 38'sd2048;

    always_comb begin
        case (r_item.brush_kind)
            KIND_PUSH, KIND_BLOAT: begin
                ex_c = pa_r[51:26];
                ey_c = pb_r[51:26];
            end
            KIND_PULL, KIND_PINCH: begin
                ex_c = -pa_r[51:26];
                ey_c = -pb_r[51:26];
            end
            KIND_TWIRL: begin
                ex_c = tx[37:12];
                ey_c = ty[37:12];
            end
            default: begin
                ex_c = '0;
                ey_c = '0;
            end
        endcase
    end

    // ---------------- read-modify-write with saturation ----------------
    logic [47:0]        rdata;
    logic signed [26:0] sum_x, sum_y;
    logic signed [23:0] new_x, new_y;
    logic               clip_x, clip_y;

    assign sum_x  = {{3{rdata[47]}}, rdata[47:24]} + {r_ex[25], r_ex};
    assign sum_y  = {{3{rdata[23]}}, rdata[23:0]}  + {r_ey[25], r_ey};
    assign clip_x = (sum_x[26:23] != 4'b0000) && (sum_x[26:23] != 4'b1111);
    assign clip_y = (sum_y[26:23] != 4'b0000) && (sum_y[26:23] != 4'b1111);
    assign new_x  = !clip_x ? sum_x[23:0] : (sum_x[26] ? 24'sh800000 : 24'sh7FFFFF);
    assign new_y  = !clip_y ? sum_y[23:0] : (sum_y[26] ? 24'sh800000 : 24'sh7FFFFF);

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    logic [47:0]   ram_wdata;
    assign ram_we    = i_ctl.init_wr || i_ctl.clr_wr || i_ctl.cell_wr;
    assign ram_wdata = i_ctl.cell_wr ? {new_x, new_y} : 48'd0;
    assign ram_re    = i_ctl.rd_item || i_ctl.rd_cell;
    assign ram_raddr = i_ctl.rd_item ? rd_addr : r_addr;

    lbg_ram #(
        .WIDTH (48),
        .DEPTH (TOTAL)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_count     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_addr <= base_c;
            end else if (i_ctl.init_wr || i_ctl.next_cell) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_ctl.load_item) begin
                r_count <= '0;
                r_sat   <= 1'b0;
            end else begin
                if (i_ctl.div_ld && (r_count != 11'd2047)) r_count <= r_count + 11'd1;
                if (i_ctl.cell_wr && (clip_x || clip_y))   r_sat   <= 1'b1;
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) r_item <= i_req;

        if (i_ctl.start) begin
            r_gx <= '0;
            r_gy <= '0;
            r_cu <= 14'(C0_Q);
            r_cv <= 14'(C0_Q);
            r_ur <= RW'(C0_R);
            r_vr <= RW'(C0_R);
            r_r2 <= r_item.brush_radius * r_item.brush_radius;
        end else if (i_ctl.next_cell) begin
            if (last_col) begin
                r_gx <= '0;
                r_cu <= 14'(C0_Q);
                r_ur <= RW'(C0_R);
                r_gy <= r_gy + GW'(1);
                if (v_carry) begin
                    r_cv <= 14'(r_cv + 14'(ST_Q) + 14'd1);
                    r_vr <= vr_sum - RW'(TWO_G);
                end else begin
                    r_cv <= 14'(r_cv + 14'(ST_Q));
                    r_vr <= vr_sum;
                end
            end else begin
                r_gx <= r_gx + GW'(1);
                if (u_carry) begin
                    r_cu <= 14'(r_cu + 14'(ST_Q) + 14'd1);
                    r_ur <= ur_sum - RW'(TWO_G);
                end else begin
                    r_cu <= 14'(r_cu + 14'(ST_Q));
                    r_ur <= ur_sum;
                end
            end
        end

        if (i_ctl.dist_ld) begin
            r_du  <= du_c;
            r_dv  <= dv_c;
            r_du2 <= du_c * du_c;
            r_dv2 <= dv_c * dv_c;
        end
        if (i_ctl.sum_ld) r_d2 <= 34'($unsigned(r_du2)) + 34'($unsigned(r_dv2));

        // t = round(N * d2 / r2), one quotient bit a cycle
        if (i_ctl.div_ld) begin
            r_rem  <= NW'(r_d2) * NW'(EXP_TABLE_SIZE) + NW'(r_r2 >> 1);
            r_dsor <= NW'(r_r2) << (QW - 1);
            r_q    <= '0;
            r_dcnt <= CW'(QW - 1);
        end else if (i_ctl.div_step) begin
            if (rem_ge) r_rem <= r_rem - r_dsor;
            r_q    <= {r_q[QW-2:0], rem_ge};
            r_dsor <= r_dsor >> 1;
            r_dcnt <= r_dcnt - CW'(1);
        end

        if (i_ctl.g_ld)   r_g   <= (r_r2 == 30'd0) ? 17'd0 : gauss_rom[q_idx];
        if (i_ctl.w_ld)   r_w30 <= $signed({1'b0, r_g}) * $signed(r_item.brush_strength);
        if (i_ctl.ang_ld) begin
            r_s  <= s_val;
            r_cm <= c_val - 19'sd65536;
        end
        if (i_ctl.mul_ld) begin
            r_pa <= ax * r_w30;
            r_pb <= ay * r_w30;
            r_t1 <= r_du * r_cm;
            r_t2 <= r_dv * r_s;
            r_t3 <= r_du * r_s;
            r_t4 <= r_dv * r_cm;
        end
        if (i_ctl.delta_ld) begin
            r_ex <= ex_c;
            r_ey <= ey_c;
        end

        if (i_ctl.out_load) begin
            r_rsp.disp_x        <= read_ok ? rdata[47:24] : 24'sd0;
            r_rsp.disp_y        <= read_ok ? rdata[23:0]  : 24'sd0;
            r_rsp.cells_changed <= r_count;
            r_rsp.saturated     <= r_sat;
        end
    end

    assign o_sts.cmd       = r_item.cmd;
    assign o_sts.slot_ok   = slot_ok;
    assign o_sts.kind_ok   = kind_ok;
    assign o_sts.init_last = r_addr == AW'(TOTAL - 1);
    assign o_sts.last_cell = last_cell;
    assign o_sts.in_radius = in_radius;
    assign o_sts.div_last  = r_dcnt == '0;
    assign o_sts.out_full  = r_out_valid;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    `LBG_ASSERT_IMP(a_out_free, i_clk, i_rst_n, i_ctl.out_load, !r_out_valid)
    `LBG_ASSERT_IMP(a_q_range, i_clk, i_rst_n, i_ctl.g_ld && (r_r2 != 30'd0), r_q <= QW'(EXP_TABLE_SIZE))
    `LBG_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, 32'(r_count) <= CELLS)
endmodule

### rtl/liquify_brush_grid.sv
// Each accepted request is decoded; a read then does one RAM read, and a no-op, invalid slot or
// unknown brush kind goes straight to done. A clear zeroes the G*G cells of the view. A brush
// tests each cell against the radius; cells inside run the serial Gaussian-index divider (9
// quotient bits at a table size of 256) and are written back. One request at a time; the grid RAM
// read-modify-write and the divider set the rate. Reset clears all NUM_VIEWS*G*G RAM words,
// ready held low. The result register lets the next request be taken while a result waits.
module liquify_brush_grid #(
    parameter int GRID_DIM       = 32,
    parameter int NUM_VIEWS      = 4,
    parameter int EXP_TABLE_SIZE = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  lbg_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output lbg_pkg::t_rsp o_rsp
);
    import lbg_pkg::*;

    t_ctl ctl;
    t_sts sts;

    lbg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    lbg_dp #(
        .GRID_DIM       (GRID_DIM),
        .NUM_VIEWS      (NUM_VIEWS),
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );
endmodule
